FILE: rtl/nfcfp_pkg.sv
`timescale 1ns / 1ps

package nfcfp_pkg;

    // Parser phases, one-hot
    typedef enum logic [10:0] {
        PH_S0      = 11'b000_0000_0001,
        PH_S1      = 11'b000_0000_0010,
        PH_S2      = 11'b000_0000_0100,
        PH_LEN     = 11'b000_0000_1000,
        PH_LCS     = 11'b000_0001_0000,
        PH_ACKPOST = 11'b000_0010_0000,
        PH_TFI     = 11'b000_0100_0000,
        PH_CMD     = 11'b000_1000_0000,
        PH_DATA    = 11'b001_0000_0000,
        PH_DCS     = 11'b010_0000_0000,
        PH_POST    = 11'b100_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_OK      = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_ERR     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_START     = 4'd1,
        ERR_LEN_SUM   = 4'd2,
        ERR_SHORT_LEN = 4'd3,
        ERR_TFI       = 4'd4,
        ERR_REPLY     = 4'd5,
        ERR_DATA_SUM  = 4'd6,
        ERR_POSTAMBLE = 4'd7,
        ERR_TARGETS   = 4'd8,
        ERR_UID_OVER  = 4'd9
    } err_t;

    // Register indexes on the config port
    localparam logic [1:0] REG_EXPECTED_REPLY = 2'd0;
    localparam logic [1:0] REG_DEVICE_TFI     = 2'd1;
    localparam logic [1:0] REG_EXTRACT_ID     = 2'd2;

    localparam logic [7:0] START_BYTE    = 8'h00;
    localparam logic [7:0] START_CODE    = 8'hFF;
    localparam logic [7:0] ACK_LCS       = 8'hFF;
    localparam logic [7:0] POSTAMBLE     = 8'h00;
    localparam logic [7:0] TFI_RESET     = 8'hD5;
    localparam logic [7:0] UID_LEN_INDEX = 8'd5;
    localparam logic [7:0] UID_START     = 8'd6;
    localparam logic [7:0] ONE_TARGET    = 8'd1;

    typedef struct packed {
        logic [7:0] expected_reply;
        logic [7:0] device_tfi;
        logic       extract_id;
    } cfg_t;

    // One decoded result plus the value-register action it carries
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] count;
        err_t       err;
        logic       shift;   // append data to the value register
        logic       mask;    // keep only the configured low bytes after the append
        logic       clear;   // zero the value register (UID length byte)
    } op_t;

endpackage

FILE: rtl/nfcfp_front.sv
`timescale 1ns / 1ps

module nfcfp_front
    import nfcfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       push,
    output op_t        op
);

    phase_t     phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] payload_index_reg, payload_index_next;
    logic [7:0] uid_length_reg, uid_length_next;
    logic       target_bad_reg, target_bad_next;
    logic       accept;
    logic [8:0] uid_end;

    assign accept  = rx_valid & ~q_full;
    assign uid_end = {1'b0, UID_START} + {1'b0, uid_length_reg};

    always_comb
    begin
        phase_next         = phase_reg;
        frame_length_next  = frame_length_reg;
        bytes_left_next    = bytes_left_reg;
        running_sum_next   = running_sum_reg;
        payload_index_next = payload_index_reg;
        uid_length_next    = uid_length_reg;
        target_bad_next    = target_bad_reg;
        push               = 1'b0;
        op                 = '0;
        op.kind            = KIND_ERR;
        op.err             = ERR_NONE;

        if (accept)
        begin
            case (phase_reg)
                PH_S0:
                begin
                    if (rx_byte != START_BYTE)
                    begin
                        push   = 1'b1;
                        op.err = ERR_START;
                    end
                    else
                        phase_next = PH_S1;
                end
                PH_S1:
                begin
                    if (rx_byte != START_BYTE)
                    begin
                        push       = 1'b1;
                        op.err     = ERR_START;
                        phase_next = PH_S0;
                    end
                    else
                        phase_next = PH_S2;
                end
                PH_S2:
                begin
                    if (rx_byte != START_CODE)
                    begin
                        push       = 1'b1;
                        op.err     = ERR_START;
                        phase_next = PH_S0;
                    end
                    else
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    frame_length_next = rx_byte;
                    phase_next        = PH_LCS;
                end
                PH_LCS:
                begin
                    if (frame_length_reg == 8'd0 && rx_byte == ACK_LCS)
                        phase_next = PH_ACKPOST;
                    else if (8'(frame_length_reg + rx_byte) != 8'd0)
                    begin
                        push       = 1'b1;
                        op.err     = ERR_LEN_SUM;
                        phase_next = PH_S0;
                    end
                    else if (frame_length_reg < 8'd2)
                    begin
                        push       = 1'b1;
                        op.err     = ERR_SHORT_LEN;
                        phase_next = PH_S0;
                    end
                    else
                    begin
                        bytes_left_next = frame_length_reg - 8'd2;
                        phase_next      = PH_TFI;
                    end
                end
                PH_ACKPOST:
                begin
                    push       = 1'b1;
                    phase_next = PH_S0;
                    if (rx_byte != POSTAMBLE)
                        op.err = ERR_POSTAMBLE;
                    else
                        op.kind = KIND_ACK;
                end
                PH_TFI:
                begin
                    if (rx_byte != cfg.device_tfi)
                    begin
                        push       = 1'b1;
                        op.err     = ERR_TFI;
                        phase_next = PH_S0;
                    end
                    else
                    begin
                        running_sum_next   = rx_byte;
                        payload_index_next = 8'd0;
                        uid_length_next    = 8'd0;
                        target_bad_next    = 1'b1;
                        phase_next         = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    if (rx_byte != cfg.expected_reply)
                    begin
                        push       = 1'b1;
                        op.err     = ERR_REPLY;
                        phase_next = PH_S0;
                    end
                    else
                    begin
                        running_sum_next = running_sum_reg + rx_byte;
                        phase_next = (bytes_left_reg == 8'd0) ? PH_DCS : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    push             = 1'b1;
                    op.kind          = KIND_PAYLOAD;
                    op.data          = rx_byte;
                    running_sum_next = running_sum_reg + rx_byte;
                    if (cfg.extract_id)
                    begin
                        if (payload_index_reg == 8'd0)
                            target_bad_next = (rx_byte != ONE_TARGET);
                        if (payload_index_reg == UID_LEN_INDEX)
                        begin
                            uid_length_next = rx_byte;
                            op.clear        = 1'b1;
                        end
                        else if (payload_index_reg >= UID_START &&
                                 {1'b0, payload_index_reg} < uid_end)
                            op.shift = 1'b1;
                    end
                    else
                    begin
                        op.shift = 1'b1;
                        op.mask  = 1'b1;
                    end
                    payload_index_next = payload_index_reg + 8'd1;
                    bytes_left_next    = bytes_left_reg - 8'd1;
                    if (bytes_left_reg == 8'd1)
                        phase_next = PH_DCS;
                end
                PH_DCS:
                begin
                    if (8'(running_sum_reg + rx_byte) != 8'd0)
                    begin
                        push       = 1'b1;
                        op.err     = ERR_DATA_SUM;
                        phase_next = PH_S0;
                    end
                    else
                        phase_next = PH_POST;
                end
                PH_POST:
                begin
                    push       = 1'b1;
                    phase_next = PH_S0;
                    if (rx_byte != POSTAMBLE)
                        op.err = ERR_POSTAMBLE;
                    else if (cfg.extract_id && target_bad_reg)
                        op.err = ERR_TARGETS;
                    else if (cfg.extract_id && (payload_index_reg < UID_START ||
                             uid_end > {1'b0, payload_index_reg}))
                        op.err = ERR_UID_OVER;
                    else
                    begin
                        op.kind  = KIND_OK;
                        op.count = payload_index_reg;
                    end
                end
                default:
                    phase_next = PH_S0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_S0;
            frame_length_reg  <= '0;
            bytes_left_reg    <= '0;
            running_sum_reg   <= '0;
            payload_index_reg <= '0;
            uid_length_reg    <= '0;
            target_bad_reg    <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            frame_length_reg  <= frame_length_next;
            bytes_left_reg    <= bytes_left_next;
            running_sum_reg   <= running_sum_next;
            payload_index_reg <= payload_index_next;
            uid_length_reg    <= uid_length_next;
            target_bad_reg    <= target_bad_next;
        end
    end

endmodule

FILE: rtl/nfcfp_queue.sv
`timescale 1ns / 1ps

module nfcfp_queue
    import nfcfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output logic full,
    output logic q_valid,
    output op_t  q_op
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_op    = slot_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/nfcfp_back.sv
`timescale 1ns / 1ps

module nfcfp_back
    import nfcfp_pkg::*;
#(
    parameter int VALUE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  op_t         q_op,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_count,
    output logic [63:0] value,
    output logic [3:0]  error_code
);

    localparam int          VALUE_BITS = 8 * VALUE_BYTES;
    localparam logic [63:0] VALUE_MASK = ~64'd0 >> (64 - VALUE_BITS);

    logic        valid_reg, valid_next;
    kind_t       kind_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  count_reg;
    logic [63:0] value_reg;
    err_t        err_reg;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] appended;

    assign pop      = q_valid & (~valid_reg | ~res_stall);
    assign appended = {shift_reg[55:0], q_op.data};

    always_comb
    begin
        valid_next = pop | (valid_reg & res_stall);
        shift_next = shift_reg;
        if (pop)
        begin
            if (q_op.kind != KIND_PAYLOAD)
                shift_next = '0;            // frame done: start the next one empty
            else if (q_op.clear)
                shift_next = '0;
            else if (q_op.shift)
                shift_next = q_op.mask ? (appended & VALUE_MASK) : appended;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= q_op.kind;
            byte_reg  <= q_op.data;
            count_reg <= q_op.count;
            err_reg   <= q_op.err;
            value_reg <= (q_op.kind == KIND_OK) ? shift_reg : 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            shift_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            shift_reg <= shift_next;
        end
    end

    assign res_valid     = valid_reg;
    assign kind          = kind_reg;
    assign payload_byte  = byte_reg;
    assign payload_count = count_reg;
    assign value         = value_reg;
    assign error_code    = err_reg;

endmodule

FILE: rtl/nfc_reader_frame_parser_core.sv
`timescale 1ns / 1ps

// Frame parser for an NFC reader link. Feed received bytes one word per cycle on
// rx_valid/rx_stall/rx_byte; each byte yields at most one result word on the
// res_* channel: a payload byte (kind 0), a good frame with payload count and value
// (kind 1), an ACK frame (kind 2) or a numbered error (kind 3), after which the
// parser waits for a new 00 00 FF start. The block takes one byte every cycle:
// the byte is checked combinationally by the front parser, the decoded result
// goes through a two-entry queue, and the back stage builds the value and holds
// the result register, so a stalled result only stops input once the queue is
// full. A byte's result word enters the queue as the byte is taken, then the
// back stage loads it into the result register that drives res_*. The value is
// the big-endian last VALUE_BYTES payload bytes, or the card UID when extract_id
// is set. Registers (APB, byte address 4*i): 0 expected_reply, 1 device_tfi
// (reset 0xD5), 2 extract_id; write them only while no frame is in flight.
module nfc_reader_frame_parser_core
    import nfcfp_pkg::*;
#(
    parameter int VALUE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_count,
    output logic [63:0] value,
    output logic [3:0]  error_code
);

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [1:0] reg_index;
    logic       push, pop, q_full, q_valid;
    op_t        push_op, q_op;

    // Register file: word-aligned, low address bits ignored
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_EXPECTED_REPLY: cfg_next.expected_reply = pwdata[7:0];
                REG_DEVICE_TFI:     cfg_next.device_tfi     = pwdata[7:0];
                REG_EXTRACT_ID:     cfg_next.extract_id     = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_EXPECTED_REPLY: prdata = {24'd0, cfg_reg.expected_reply};
            REG_DEVICE_TFI:     prdata = {24'd0, cfg_reg.device_tfi};
            REG_EXTRACT_ID:     prdata = {31'd0, cfg_reg.extract_id};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_reply <= 8'd0;
            cfg_reg.device_tfi     <= TFI_RESET;
            cfg_reg.extract_id     <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Hold input while the queue has no room
    assign rx_stall = q_full;

    nfcfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rx_valid (rx_valid),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (push),
        .op       (push_op)
    );

    nfcfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    nfcfp_back #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .pop           (pop),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .payload_count (payload_count),
        .value         (value),
        .error_code    (error_code)
    );

endmodule

FILE: verif/nfc_reader_frame_parser_core_tb.sv
`timescale 1ns / 1ps

import nfcfp_pkg::*;

// Tracks the frame parser state on the accepted byte stream and holds the result
// words that the block still owes.
class frame_tracker #(int VB = 8);
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  count;
        logic [63:0] val;
        err_t        err;
    } parse_word_t;

    logic [7:0]  reply_code;
    logic [7:0]  tfi_code;
    logic        id_mode;

    phase_t      phase;
    logic [7:0]  frame_len;
    logic [7:0]  left;
    logic [7:0]  csum;
    logic [7:0]  pidx;
    logic [7:0]  uid_len;
    logic [63:0] shreg;
    logic        targ_bad;

    parse_word_t expected_words[$];
    int          fail_count;
    int          word_count;

    function new();
        restart();
    endfunction

    function void restart();
        reply_code = 8'h00;
        tfi_code   = TFI_RESET;
        id_mode    = 1'b0;
        phase      = PH_S0;
        frame_len  = '0;
        left       = '0;
        csum       = '0;
        pidx       = '0;
        uid_len    = '0;
        shreg      = '0;
        targ_bad   = 1'b0;
        expected_words.delete();
        fail_count = 0;
        word_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] d);
        case (idx)
            REG_EXPECTED_REPLY: reply_code = d[7:0];
            REG_DEVICE_TFI:     tfi_code = d[7:0];
            REG_EXTRACT_ID:     id_mode = d[0];
            default: ;
        endcase
    endfunction

    function void expect_word(kind_t k, logic [7:0] d, logic [7:0] c, logic [63:0] v,
                              err_t e);
        parse_word_t w;
        w.kind  = k;
        w.data  = d;
        w.count = c;
        w.val   = v;
        w.err   = e;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function void abort_frame(err_t code);
        phase = PH_S0;
        expect_word(KIND_ERR, 8'h00, 8'h00, 64'h0, code);
    endfunction

    function void parse_byte(logic [7:0] b);
        logic [7:0] sum8;
        int         pi;
        int         ul;
        pi = int'(pidx);
        ul = int'(uid_len);
        case (phase)
            PH_S0:
                if (b != START_BYTE) abort_frame(ERR_START);
                else phase = PH_S1;
            PH_S1:
                if (b != START_BYTE) abort_frame(ERR_START);
                else phase = PH_S2;
            PH_S2:
                if (b != START_CODE) abort_frame(ERR_START);
                else phase = PH_LEN;
            PH_LEN:
            begin
                frame_len = b;
                phase = PH_LCS;
            end
            PH_LCS:
            begin
                sum8 = frame_len + b;
                // ACK is recognized before the length sum
                if (frame_len == 8'd0 && b == ACK_LCS)
                    phase = PH_ACKPOST;
                else if (sum8 != 8'd0)
                    abort_frame(ERR_LEN_SUM);
                else if (frame_len < 8'd2)
                    abort_frame(ERR_SHORT_LEN);
                else
                begin
                    left = frame_len - 8'd2;
                    phase = PH_TFI;
                end
            end
            PH_ACKPOST:
                if (b != POSTAMBLE) abort_frame(ERR_POSTAMBLE);
                else
                begin
                    phase = PH_S0;
                    expect_word(KIND_ACK, 8'h00, 8'h00, 64'h0, ERR_NONE);
                end
            PH_TFI:
                if (b != tfi_code) abort_frame(ERR_TFI);
                else
                begin
                    csum     = b;
                    pidx     = '0;
                    uid_len  = '0;
                    shreg    = '0;
                    targ_bad = 1'b1;
                    phase    = PH_CMD;
                end
            PH_CMD:
                if (b != reply_code) abort_frame(ERR_REPLY);
                else
                begin
                    csum  = csum + b;
                    phase = (left == 8'd0) ? PH_DCS : PH_DATA;
                end
            PH_DATA:
            begin
                csum = csum + b;
                if (id_mode)
                begin
                    if (pidx == 8'd0) targ_bad = (b != ONE_TARGET);
                    if (pidx == UID_LEN_INDEX)
                    begin
                        uid_len = b;
                        shreg = '0;
                    end
                    else if (pi >= int'(UID_START) && pi < int'(UID_START) + ul)
                    begin
                        shreg = {shreg[55:0], b};
                    end
                end
                else
                begin
                    shreg = {shreg[55:0], b} & ({64{1'b1}} >> (64 - 8 * VB));
                end
                pidx = pidx + 8'd1;
                left = left - 8'd1;
                if (left == 8'd0) phase = PH_DCS;
                expect_word(KIND_PAYLOAD, b, 8'h00, 64'h0, ERR_NONE);
            end
            PH_DCS:
            begin
                sum8 = csum + b;
                if (sum8 != 8'd0) abort_frame(ERR_DATA_SUM);
                else phase = PH_POST;
            end
            PH_POST:
                if (b != POSTAMBLE) abort_frame(ERR_POSTAMBLE);
                else if (id_mode && targ_bad) abort_frame(ERR_TARGETS);
                else if (id_mode && (pi < int'(UID_START) || int'(UID_START) + ul > pi))
                    abort_frame(ERR_UID_OVER);
                else
                begin
                    phase = PH_S0;
                    expect_word(KIND_OK, 8'h00, pidx, shreg, ERR_NONE);
                end
            default:
                phase = PH_S0;
        endcase
    endfunction

    function void check_word(logic [1:0] k, logic [7:0] d, logic [7:0] c, logic [63:0] v,
                             logic [3:0] e);
        parse_word_t want;
        word_count++;
        if (expected_words.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result word %0d: none expected, ", word_count,
                         "got kind %0d byte %02h count %0d value %016h code %0d",
                         k, d, c, v, e);
            return;
        end
        want = expected_words.pop_front();
        if (want.kind !== k || want.data !== d || want.count !== c || want.val !== v
            || want.err !== e)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("result word %0d: expected ", word_count,
                         "kind %0d byte %02h count %0d value %016h code %0d",
                         want.kind, want.data, want.count, want.val, want.err);
                $display("result word %0d:      got ", word_count,
                         "kind %0d byte %02h count %0d value %016h code %0d",
                         k, d, c, v, e);
            end
        end
    endfunction
endclass

module nfc_reader_frame_parser_core_tb;

    localparam int VALUE_BYTES = 8;
    localparam int ITEM_TARGET = 1150;
    // Keep a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT = 400000;

    // How a generated frame is broken, if at all
    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_LCS,
        FLAW_TFI,
        FLAW_CMD,
        FLAW_DCS,
        FLAW_POST
    } flaw_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_count;
    logic [63:0] value;
    logic [3:0]  error_code;

    frame_tracker #(VALUE_BYTES) sb;

    // 0: no idling, 1: occasional bursts, 2: frequent bursts
    int          idle_mode = 0;
    int          bytes_sent = 0;
    int unsigned cycle_count = 0;

    // Bytes of the frames under construction, and the payload being built
    logic [7:0]  tx_bytes[$];
    logic [7:0]  pl[$];

    nfc_reader_frame_parser_core #(
        .VALUE_BYTES(VALUE_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .payload_count(payload_count),
        .value        (value),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check every result word taken at this edge against the oldest expectation.
    // Values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (sb != null && rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
            sb.check_word(kind, payload_byte, payload_count, value, error_code);
    end

    // Stall the result side in bursts of random length while idling is on.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 15 : 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Append a byte to the outgoing stream or to the payload being built.
    function automatic void add_tx(logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endfunction

    function automatic void add_pl(logic [7:0] b);
        pl.insert(pl.size(), b);
    endfunction

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] any_nonzero();
        return 8'($urandom_range(1, 255));
    endfunction

    // Register value for a phase: mostly the extremes or the usual code.
    function automatic logic [7:0] pick_code(logic [7:0] usual);
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return usual;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void fill_random(int n);
        pl.delete();
        repeat (n) add_pl(any_byte());
    endfunction

    // Passive target list: one target, tag, two card type bytes, select byte,
    // UID length, UID.
    function automatic void fill_targets(int uid_n);
        pl.delete();
        add_pl(ONE_TARGET);
        repeat (4) add_pl(any_byte());
        add_pl(8'(uid_n));
        repeat (uid_n) add_pl(any_byte());
    endfunction

    // Wrap the current payload in a full information frame, addressed with the
    // codes the block is set up for, and break it as asked.
    function automatic void queue_frame(flaw_t flaw);
        logic [7:0] len;
        logic [7:0] lcs;
        logic [7:0] tfi;
        logic [7:0] cmd;
        logic [7:0] dsum;
        len = 8'(pl.size() + 2);
        lcs = 8'h00 - len;
        if (flaw == FLAW_LCS) lcs = lcs + any_nonzero();
        tfi = sb.tfi_code;
        if (flaw == FLAW_TFI) tfi = tfi ^ any_nonzero();
        cmd = sb.reply_code;
        if (flaw == FLAW_CMD) cmd = cmd ^ any_nonzero();
        dsum = tfi + cmd;
        foreach (pl[i]) dsum = dsum + pl[i];
        add_tx(START_BYTE);
        add_tx(flaw == FLAW_START ? any_nonzero() : START_BYTE);
        add_tx(START_CODE);
        add_tx(len);
        add_tx(lcs);
        add_tx(tfi);
        add_tx(cmd);
        foreach (pl[i]) add_tx(pl[i]);
        add_tx((8'h00 - dsum) ^ (flaw == FLAW_DCS ? any_nonzero() : 8'h00));
        add_tx(flaw == FLAW_POST ? any_nonzero() : POSTAMBLE);
    endfunction

    // Start, LEN and LCS only; the parser goes on with whatever follows.
    function automatic void queue_header(logic [7:0] len, logic [7:0] lcs);
        add_tx(START_BYTE);
        add_tx(START_BYTE);
        add_tx(START_CODE);
        add_tx(len);
        add_tx(lcs);
    endfunction

    // Offer one byte word, after an optional gap, and hold it until taken.
    // Valid stays high on return so back-to-back words stream without a bubble.
    task automatic send_byte(logic [7:0] b);
        if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 15 : 3) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall !== 1'b0);
        sb.parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
    endtask

    // Bring the parser back to waiting for a start byte, drop valid, drain every
    // owed result and give the back stage time to settle.
    task automatic settle();
        while (sb.phase != PH_S0) send_byte(any_byte());
        rx_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    // Upper data bits are random; only the low bits of each register count.
    task automatic configure(logic [7:0] reply, logic [7:0] tfi, logic id);
        settle();
        write_reg(REG_EXPECTED_REPLY, {24'($urandom), reply});
        write_reg(REG_DEVICE_TFI, {24'($urandom), tfi});
        write_reg(REG_EXTRACT_ID, {31'($urandom), id});
    endtask

    initial
    begin
        int    phase_end;
        int    pick;
        flaw_t flaw;
        logic [7:0] len;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part, reset register values ----
        // Stray byte, then a start sequence whose third byte is not FF
        add_tx(8'hA5);
        add_tx(START_BYTE);
        add_tx(START_BYTE);
        add_tx(START_BYTE);
        // ACK, then ACK with a bad postamble
        queue_header(8'h00, ACK_LCS);
        add_tx(POSTAMBLE);
        queue_header(8'h00, ACK_LCS);
        add_tx(8'h01);
        // Short lengths that pass the sum, then a bad length sum
        queue_header(8'h00, 8'h00);
        queue_header(8'h01, 8'hFF);
        queue_header(8'h05, 8'h00);
        // Empty payload: command byte goes straight to DCS
        fill_random(0);
        queue_frame(FLAW_NONE);
        // More than eight payload bytes, with both byte extremes inside
        fill_random(12);
        pl[3] = 8'h00;
        pl[9] = 8'hFF;
        queue_frame(FLAW_NONE);
        send_queued();

        // One broken frame per error; resync after each so the next stays clean
        for (int f = FLAW_START; f <= FLAW_POST; f++)
        begin
            fill_random(5);
            queue_frame(flaw_t'(f));
            send_queued();
            settle();
        end

        // Longest frame: LEN FF
        fill_random(253);
        queue_frame(FLAW_NONE);
        send_queued();

        // ---- Directed part, ID mode with extreme codes ----
        configure(8'hFF, 8'h00, 1'b1);
        fill_targets(4);
        queue_frame(FLAW_NONE);
        // UID longer than the value register: keep the last eight bytes
        fill_targets(10);
        queue_frame(FLAW_NONE);
        fill_targets(0);
        queue_frame(FLAW_NONE);
        // Wrong target count
        fill_targets(4);
        pl[0] = 8'h02;
        queue_frame(FLAW_NONE);
        // Empty payload in ID mode
        fill_random(0);
        queue_frame(FLAW_NONE);
        // Too short to hold the UID length byte
        fill_random(3);
        pl[0] = ONE_TARGET;
        queue_frame(FLAW_NONE);
        // UID length byte claims more bytes than the payload holds
        fill_targets(7);
        repeat (4) void'(pl.pop_back());
        queue_frame(FLAW_NONE);
        send_queued();

        configure(8'h4B, 8'hFF, 1'b0);
        fill_random(8);
        queue_frame(FLAW_NONE);
        send_queued();

        // ---- Random part: phases with their own settings and idling ----
        while (bytes_sent < ITEM_TARGET)
        begin
            idle_mode = (bytes_sent > ITEM_TARGET - 150) ? 0 : $urandom_range(0, 2);
            configure(pick_code(8'h4B), pick_code(TFI_RESET), 1'($urandom_range(0, 1)));
            phase_end = bytes_sent + $urandom_range(120, 220);
            while (bytes_sent < phase_end && bytes_sent < ITEM_TARGET)
            begin
                // Hold the tail of the run free of idling
                if (bytes_sent > ITEM_TARGET - 150) idle_mode = 0;
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    repeat ($urandom_range(1, 4)) add_tx(any_byte());
                end
                else if (pick < 12)
                begin
                    queue_header(8'h00, ACK_LCS);
                    add_tx($urandom_range(0, 3) == 0 ? any_nonzero() : POSTAMBLE);
                end
                else if (pick < 18)
                begin
                    len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) : any_byte();
                    queue_header(len, ($urandom_range(0, 1) == 0) ? 8'h00 - len : any_byte());
                end
                else
                begin
                    if (sb.id_mode && $urandom_range(0, 7) != 0)
                    begin
                        fill_targets($urandom_range(0, 10));
                        case ($urandom_range(0, 7))
                            0: pl[0] = any_byte();
                            1: repeat ($urandom_range(1, pl.size())) void'(pl.pop_back());
                            default: ;
                        endcase
                    end
                    else
                    begin
                        fill_random(($urandom_range(0, 39) == 0) ? $urandom_range(100, 253)
                                                                 : $urandom_range(0, 16));
                    end
                    flaw = ($urandom_range(0, 3) == 0) ? flaw_t'($urandom_range(1, 6))
                                                       : FLAW_NONE;
                    queue_frame(flaw);
                end
                send_queued();
            end
        end

        // ---- Drain and report ----
        idle_mode = 0;
        rx_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.fail_count == 0 && sb.expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: nfc_reader_frame_parser_core.f
rtl/nfcfp_pkg.sv
rtl/nfcfp_front.sv
rtl/nfcfp_queue.sv
rtl/nfcfp_back.sv
rtl/nfc_reader_frame_parser_core.sv
verif/nfc_reader_frame_parser_core_tb.sv
